[rtl/tate_pkg.sv]
// Shared types, constants and helpers for the two-way ranging anchor engine.
// No dependencies; imported by tate_tof_unit and twr_anchor_tof_engine_core.
package tate_pkg;

    // Default timestamp width, the default of the STAMP_BITS parameter
    localparam int STAMP_BITS_DEF = 40;

    // Time of flight result width (fixed, signed)
    localparam int TOF_BITS = 41;

    // Digit width of the shared multiplier pass
    localparam int DIGIT_BITS = 8;

    // Register width, reset value and idle count ceiling
    localparam int TIMEOUT_BITS = 16;
    localparam logic [TIMEOUT_BITS-1:0] IDLE_TIMEOUT_RESET = 16'd300;
    localparam logic [TIMEOUT_BITS-1:0] IDLE_COUNT_MAX = 16'hFFFF;

    // Input item field widths
    localparam int CMD_BITS = 2;
    localparam int MSG_BITS = 8;

    // Commands
    localparam logic [CMD_BITS-1:0] CMD_FRAME    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ACK_DONE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd2;

    // Message kinds
    localparam logic [MSG_BITS-1:0] MSG_POLL         = 8'd0;
    localparam logic [MSG_BITS-1:0] MSG_RANGE        = 8'd2;
    localparam logic [MSG_BITS-1:0] MSG_RANGE_REPORT = 8'd3;
    localparam logic [MSG_BITS-1:0] MSG_NONE         = 8'd255;

    // Expected next message
    localparam logic [1:0] AWAIT_POLL   = 2'd0;
    localparam logic [1:0] AWAIT_RANGE  = 2'd1;
    localparam logic [1:0] AWAIT_REPORT = 2'd2;

    // Saturation bounds of the time of flight
    localparam logic [TOF_BITS-1:0] TOF_NEG_MAG = TOF_BITS'(1) << (TOF_BITS - 1);
    localparam logic [TOF_BITS-1:0] TOF_POS_MAX = TOF_NEG_MAG - TOF_BITS'(1);

    // One result item, first field in the highest bits
    typedef struct packed {
        logic [1:0]                 awaiting;
        logic                       sequence_failed;
        logic                       divide_error;
        logic signed [TOF_BITS-1:0] time_of_flight;
        logic                       tof_valid;
        logic                       send_poll_ack;
    } out_item_t;

    localparam int OUT_FIELD_BITS = $bits(out_item_t);
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Status of the time of flight unit toward the sequencer
    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic                       tof_valid;
        logic                       divide_error;
        logic signed [TOF_BITS-1:0] time_of_flight;
    } tof_stat_t;

    // Message code that the expected-kind state stands for
    function automatic logic [MSG_BITS-1:0] kind_code(input logic [1:0] kind);
        logic [MSG_BITS-1:0] code;
        unique case (kind)
            AWAIT_POLL:   code = MSG_POLL;
            AWAIT_RANGE:  code = MSG_RANGE;
            AWAIT_REPORT: code = MSG_RANGE_REPORT;
            default:      code = MSG_NONE;
        endcase
        return code;
    endfunction

endpackage

[rtl/tate_tof_unit.sv]
// Iterative time of flight unit: digit-serial products, then restoring division.
// Depends on tate_pkg.
module tate_tof_unit
    import tate_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [STAMP_BITS-1:0] round1,
    input  logic [STAMP_BITS-1:0] reply1,
    input  logic [STAMP_BITS-1:0] round2,
    input  logic [STAMP_BITS-1:0] reply2,
    output tof_stat_t             stat
);

    localparam int DW     = STAMP_BITS + 2;               // divisor width
    localparam int NW     = 2 * STAMP_BITS;               // numerator magnitude width
    localparam int AW     = NW + 1;                       // signed accumulator width
    localparam int DIGITS = (STAMP_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int KW     = $clog2(DIGITS);
    localparam int BPW    = DIGITS * DIGIT_BITS;
    localparam int PPW    = STAMP_BITS + DIGIT_BITS;
    localparam int CW     = (NW > DW + TOF_BITS) ? NW : DW + TOF_BITS;
    localparam int QCW    = $clog2(TOF_BITS);

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_ABS, U_CHK, U_DIV, U_FIN} ustate_t;

    ustate_t                     st_reg, st_next;
    logic [STAMP_BITS-1:0]       mul_a_reg, mul_a_next;
    logic [BPW-1:0]              mul_b_reg, mul_b_next;
    logic [STAMP_BITS-1:0]       sec_a_reg, sec_a_next;
    logic [STAMP_BITS-1:0]       sec_b_reg, sec_b_next;
    logic                        phase_reg, phase_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [AW-1:0]               acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic [NW-1:0]               num_reg, num_next;
    logic [DW-1:0]               d_reg, d_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [TOF_BITS-1:0]         q_reg, q_next;
    logic [QCW-1:0]              qc_reg, qc_next;
    logic                        sat_reg, sat_next;
    logic                        derr_reg, derr_next;
    logic                        done_reg, done_next;
    logic                        valid_reg, valid_next;
    logic [TOF_BITS-1:0]         tof_reg, tof_next;

    logic [DIGIT_BITS-1:0]       digit;
    logic [PPW-1:0]              pp;
    logic [AW-1:0]               pp_sh;
    logic [AW-1:0]               acc_neg;
    logic [DW:0]                 trial;
    logic [DW:0]                 trial_diff;
    logic                        trial_ge;
    logic [TOF_BITS-1:0]         mag;

    // Shared datapath: one SB x 8 digit product, one wide add, one trial subtract
    assign digit      = mul_b_reg[k_reg * DIGIT_BITS +: DIGIT_BITS];
    assign pp         = PPW'(mul_a_reg) * PPW'(digit);
    assign pp_sh      = AW'(pp) << (k_reg * DIGIT_BITS);
    assign acc_neg    = ~acc_reg + AW'(1);
    assign trial      = {rem_reg, q_reg[TOF_BITS-1]};
    assign trial_diff = trial - {1'b0, d_reg};
    assign trial_ge   = (trial >= {1'b0, d_reg});

    always_comb begin
        st_next    = st_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        sec_a_next = sec_a_reg;
        sec_b_next = sec_b_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        qc_next    = qc_reg;
        sat_next   = sat_reg;
        derr_next  = derr_reg;
        done_next  = done_reg;
        valid_next = valid_reg;
        tof_next   = tof_reg;
        mag        = q_reg;

        unique case (st_reg)
            U_IDLE: begin
                if (start) begin
                    mul_a_next = round1;
                    mul_b_next = BPW'(round2);
                    sec_a_next = reply1;
                    sec_b_next = reply2;
                    d_next     = DW'(round1) + DW'(round2) + DW'(reply1) + DW'(reply2);
                    acc_next   = '0;
                    k_next     = '0;
                    phase_next = 1'b0;
                    sat_next   = 1'b0;
                    derr_next  = 1'b0;
                    done_next  = 1'b0;
                    st_next    = U_MUL;
                end
            end
            U_MUL: begin
                // add round1*round2, then subtract reply1*reply2
                acc_next = phase_reg ? (acc_reg - pp_sh) : (acc_reg + pp_sh);
                if (k_reg == KW'(DIGITS - 1)) begin
                    k_next = '0;
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                        mul_a_next = sec_a_reg;
                        mul_b_next = BPW'(sec_b_reg);
                    end else begin
                        st_next = U_ABS;
                    end
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            U_ABS: begin
                neg_next = acc_reg[AW-1];
                num_next = acc_reg[AW-1] ? acc_neg[NW-1:0] : acc_reg[NW-1:0];
                st_next  = U_CHK;
            end
            U_CHK: begin
                if (d_reg == '0) begin
                    derr_next = 1'b1;
                    st_next   = U_FIN;
                end else if (CW'(num_reg) >= (CW'(d_reg) << TOF_BITS)) begin
                    // quotient has bits above the result width
                    sat_next = 1'b1;
                    st_next  = U_FIN;
                end else begin
                    rem_next = DW'(num_reg >> TOF_BITS);
                    q_next   = num_reg[TOF_BITS-1:0];
                    qc_next  = '0;
                    st_next  = U_DIV;
                end
            end
            U_DIV: begin
                rem_next = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
                q_next   = {q_reg[TOF_BITS-2:0], trial_ge};
                if (qc_reg == QCW'(TOF_BITS - 1)) begin
                    st_next = U_FIN;
                end else begin
                    qc_next = qc_reg + QCW'(1);
                end
            end
            U_FIN: begin
                if (derr_reg) begin
                    valid_next = 1'b0;
                    tof_next   = '0;
                end else if (neg_reg) begin
                    mag        = (sat_reg || q_reg > TOF_NEG_MAG) ? TOF_NEG_MAG : q_reg;
                    valid_next = 1'b1;
                    tof_next   = ~mag + TOF_BITS'(1);
                end else begin
                    valid_next = 1'b1;
                    tof_next   = (sat_reg || q_reg[TOF_BITS-1]) ? TOF_POS_MAX : q_reg;
                end
                done_next = 1'b1;
                st_next   = U_IDLE;
            end
            default: st_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= U_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            derr_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            derr_reg  <= derr_next;
        end
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        sec_a_reg <= sec_a_next;
        sec_b_reg <= sec_b_next;
        phase_reg <= phase_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        qc_reg    <= qc_next;
        sat_reg   <= sat_next;
        tof_reg   <= tof_next;
    end

    assign stat.busy           = (st_reg != U_IDLE);
    assign stat.done           = done_reg;
    assign stat.tof_valid      = valid_reg;
    assign stat.divide_error   = derr_reg;
    assign stat.time_of_flight = tof_reg;

endmodule

[rtl/twr_anchor_tof_engine_core.sv]
// Top level of the two-way ranging anchor engine: event sequencer, protocol state
// and result register. Depends on tate_pkg and tate_tof_unit.
//
// Anchor side of asymmetric double-sided two-way ranging. Each request on the
// s_axis side is one event (frame received, poll-ack transmit done, or a
// millisecond tick) and produces exactly one result request on the m_axis side.
// Ticks, transmit-done events and every frame other than a range frame that
// passes the sequence check finish directly: the result lands in the output
// register at the accepting edge. A range frame that passes the check starts the
// shared time of flight unit, which forms both 2*STAMP_BITS-bit products with a
// STAMP_BITS x 8 digit multiplier and then runs a one-bit-per-cycle restoring
// divider over the 41 result bits; the block accepts no new request meanwhile.
// A zero divisor or a quotient beyond the result range skips the divider.
// Quotients beyond the 41-bit signed range saturate, and a zero divisor reports
// divide_error with tof_valid low. A new request is taken only while the output
// register is empty or drained at the same edge, so a stalled result holds off
// the input. The user must write idle_timeout_ms through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this.
module twr_anchor_tof_engine_core
    import tate_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int IN_DATA_BITS = ((MSG_BITS + 4 * STAMP_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration: idle_timeout_ms
    input  logic                     cfg_wr_en,
    input  logic [TIMEOUT_BITS-1:0]  cfg_wr_data,
    // event requests
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // msg_id, local_time, tag_poll_sent, tag_ack_received, tag_range_sent, zero pad
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_BITS-1:0]      s_axis_tuser,
    // result requests
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // send_poll_ack, tof_valid, time_of_flight, divide_error, sequence_failed,
    // awaiting, zero pad
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    localparam int SB = STAMP_BITS;

    typedef enum logic {ST_IDLE, ST_BUSY} state_t;

    // Protocol state
    state_t                  st_reg, st_next;
    logic [TIMEOUT_BITS-1:0] timeout_reg, timeout_next;
    logic [1:0]              expected_reg, expected_next;
    logic                    failed_reg, failed_next;
    logic [SB-1:0]           poll_rx_reg, poll_rx_next;
    logic [SB-1:0]           ack_tx_reg, ack_tx_next;
    logic [TIMEOUT_BITS-1:0] idle_reg, idle_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg, m_data_next;

    // Request fields
    logic [CMD_BITS-1:0] in_cmd;
    logic [MSG_BITS-1:0] in_msg;
    logic [SB-1:0]       in_local;
    logic [SB-1:0]       in_tag_poll;
    logic [SB-1:0]       in_tag_ackrx;
    logic [SB-1:0]       in_tag_range;

    // Event decode results
    logic                    ev_fail;
    logic [1:0]              ev_expected;
    logic [SB-1:0]           ev_poll_rx;
    logic [SB-1:0]           ev_ack_tx;
    logic [TIMEOUT_BITS-1:0] ev_idle;
    logic                    ev_send;
    logic                    ev_compute;
    logic                    ev_fail_chk;
    logic [TIMEOUT_BITS-1:0] tick_count;

    logic      accept;
    logic      out_free;
    logic      tof_start;
    tof_stat_t tof_stat;
    out_item_t ev_item;
    out_item_t tof_item;
    out_item_t m_item;

    logic [SB-1:0] iv_round1;
    logic [SB-1:0] iv_reply1;
    logic [SB-1:0] iv_round2;
    logic [SB-1:0] iv_reply2;

    assign in_cmd       = s_axis_tuser;
    assign in_msg       = s_axis_tdata[MSG_BITS-1:0];
    assign in_local     = s_axis_tdata[MSG_BITS +: SB];
    assign in_tag_poll  = s_axis_tdata[MSG_BITS + SB +: SB];
    assign in_tag_ackrx = s_axis_tdata[MSG_BITS + 2 * SB +: SB];
    assign in_tag_range = s_axis_tdata[MSG_BITS + 3 * SB +: SB];

    // Take a request only when idle and the result slot frees up this cycle
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (st_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Intervals, each wrapping modulo 2^STAMP_BITS
    assign iv_round1 = in_tag_ackrx - in_tag_poll;
    assign iv_reply1 = ack_tx_reg - poll_rx_reg;
    assign iv_round2 = in_local - ack_tx_reg;
    assign iv_reply2 = in_tag_range - in_tag_ackrx;

    assign tick_count = (idle_reg == IDLE_COUNT_MAX) ? idle_reg : idle_reg + TIMEOUT_BITS'(1);

    // Event decode: what the protocol state becomes if this request is taken
    always_comb begin
        ev_fail     = failed_reg;
        ev_expected = expected_reg;
        ev_poll_rx  = poll_rx_reg;
        ev_ack_tx   = ack_tx_reg;
        ev_idle     = idle_reg;
        ev_send     = 1'b0;
        ev_compute  = 1'b0;
        ev_fail_chk = failed_reg || (in_msg != kind_code(expected_reg));

        unique case (in_cmd)
            CMD_FRAME: begin
                ev_fail = ev_fail_chk;
                case (in_msg)
                    MSG_POLL: begin
                        ev_fail     = 1'b0;
                        ev_poll_rx  = in_local;
                        ev_expected = AWAIT_RANGE;
                        ev_send     = 1'b1;
                        ev_idle     = '0;
                    end
                    MSG_RANGE: begin
                        // compute only on a clean sequence
                        ev_compute  = !ev_fail_chk;
                        ev_expected = AWAIT_REPORT;
                        ev_idle     = '0;
                    end
                    MSG_RANGE_REPORT: begin
                        ev_idle = '0;
                    end
                    default: ;
                endcase
            end
            CMD_ACK_DONE: begin
                ev_ack_tx = in_local;
                ev_idle   = '0;
            end
            CMD_TICK: begin
                // drop back to awaiting a poll once idle time exceeds the timeout
                if (tick_count > timeout_reg) begin
                    ev_expected = AWAIT_POLL;
                    ev_idle     = '0;
                end else begin
                    ev_idle = tick_count;
                end
            end
            default: ;
        endcase
    end

    // Result of an event that needs no range computation
    always_comb begin
        ev_item                 = '0;
        ev_item.send_poll_ack   = ev_send;
        ev_item.sequence_failed = ev_fail;
        ev_item.awaiting        = ev_expected;
    end

    // Result of a range computation
    always_comb begin
        tof_item                 = '0;
        tof_item.tof_valid       = tof_stat.tof_valid;
        tof_item.time_of_flight  = tof_stat.time_of_flight;
        tof_item.divide_error    = tof_stat.divide_error;
        tof_item.sequence_failed = failed_reg;
        tof_item.awaiting        = expected_reg;
    end

    assign tof_start = accept && ev_compute;

    tate_tof_unit #(
        .STAMP_BITS (STAMP_BITS)
    ) u_tof (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tof_start),
        .round1  (iv_round1),
        .reply1  (iv_reply1),
        .round2  (iv_round2),
        .reply2  (iv_reply2),
        .stat    (tof_stat)
    );

    // Sequencer
    always_comb begin
        st_next       = st_reg;
        timeout_next  = cfg_wr_en ? cfg_wr_data : timeout_reg;
        expected_next = expected_reg;
        failed_next   = failed_reg;
        poll_rx_next  = poll_rx_reg;
        ack_tx_next   = ack_tx_reg;
        idle_next     = idle_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    expected_next = ev_expected;
                    failed_next   = ev_fail;
                    poll_rx_next  = ev_poll_rx;
                    ack_tx_next   = ev_ack_tx;
                    idle_next     = ev_idle;
                    if (ev_compute) begin
                        st_next = ST_BUSY;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = OUT_DATA_BITS'(ev_item);
                    end
                end
            end
            ST_BUSY: begin
                // hold the unit's result until the slot is free
                if (tof_stat.done && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_BITS'(tof_item);
                    st_next      = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            timeout_reg  <= IDLE_TIMEOUT_RESET;
            expected_reg <= AWAIT_POLL;
            failed_reg   <= 1'b0;
            poll_rx_reg  <= '0;
            ack_tx_reg   <= '0;
            idle_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_reg       <= st_next;
            timeout_reg  <= timeout_next;
            expected_reg <= expected_next;
            failed_reg   <= failed_next;
            poll_rx_reg  <= poll_rx_next;
            ack_tx_reg   <= ack_tx_next;
            idle_reg     <= idle_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_item        = out_item_t'(m_data_reg[OUT_FIELD_BITS-1:0]);

    // A result never reports both a time of flight and a divide error
    a_tof_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_item.tof_valid && m_item.divide_error))
        else $error("tof_valid and divide_error set together");

    // A poll-ack request always leaves a clean sequence awaiting a range frame
    a_poll_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item.send_poll_ack) |->
            (m_item.awaiting == AWAIT_RANGE) && !m_item.sequence_failed)
        else $error("poll-ack with wrong sequence state");

    // A time of flight comes only from a clean range frame
    a_tof_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item.tof_valid) |->
            (m_item.awaiting == AWAIT_REPORT) && !m_item.sequence_failed)
        else $error("time of flight with wrong sequence state");

    // The shared unit runs only while the sequencer waits on it
    a_unit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tof_stat.busy |-> (st_reg == ST_BUSY) && !s_axis_tready)
        else $error("unit busy outside of a range computation");

endmodule
